@@ hdl/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, constants and seven-segment encoding for the two-way
// traffic light controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

	localparam int CFG_AW = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_YELLOW = 2'd0;
	localparam logic [1:0] REG_ADJUST = 2'd1;
	localparam logic [1:0] REG_MINSTEP = 2'd2;
	localparam logic [1:0] REG_TPS = 2'd3;

	localparam logic [3:0] YELLOW_RST = 4'd3;
	localparam logic [3:0] ADJUST_RST = 4'd5;
	localparam logic [6:0] MINSTEP_RST = 7'd15;
	localparam logic [9:0] TPS_RST = 10'd1000;

	localparam logic [6:0] STEP_NS_RST = 7'd23;
	localparam logic [6:0] STEP_WE_RST = 7'd20;
	localparam logic [7:0] COUNT_MAX = 8'd99;

	// key bit positions in the active-high pressed vector
	localparam int KEY_RUN = 0;
	localparam int KEY_HALT = 1;
	localparam int KEY_ADD = 2;

	localparam logic [2:0] LAMP_GREEN = 3'b001;
	localparam logic [2:0] LAMP_YELLOW = 3'b010;
	localparam logic [2:0] LAMP_RED = 3'b100;
	localparam logic [2:0] LAMP_ALL = 3'b111;

	localparam logic [7:0] SEG_BLANK = 8'hff;

	localparam logic [7:0] SEG_TABLE [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	typedef struct packed {
		logic [3:0] yellow;
		logic [3:0] adjust;
		logic [6:0] min_step;
		logic [9:0] tps;
	} cfg_t;

	typedef struct packed {
		logic [2:0] lamps_ns;
		logic [2:0] lamps_we;
		logic [6:0] count_ns;
		logic [6:0] count_we;
		logic running;
	} res_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		if (digit > 4'd9) begin
			code = SEG_BLANK;
		end else begin
			code = ~SEG_TABLE[digit];
		end
		return code;
	endfunction

endpackage

@@ hdl/tlc_cfg.sv @@
// ----------------------------------------------------------------------------
// tlc_cfg
// APB register file: yellow length, adjust step, minimum step, ticks/second.
// ----------------------------------------------------------------------------
module tlc_cfg import tlc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t cfg
);

	logic wr_en;
	logic [1:0] idx;
	cfg_t cfg_q;

	assign idx = paddr[3:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yellow <= YELLOW_RST;
			cfg_q.adjust <= ADJUST_RST;
			cfg_q.min_step <= MINSTEP_RST;
			cfg_q.tps <= TPS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_YELLOW: cfg_q.yellow <= pwdata[3:0];
				REG_ADJUST: cfg_q.adjust <= pwdata[3:0];
				REG_MINSTEP: cfg_q.min_step <= pwdata[6:0];
				REG_TPS: cfg_q.tps <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_YELLOW: prdata = {28'd0, cfg_q.yellow};
			REG_ADJUST: prdata = {28'd0, cfg_q.adjust};
			REG_MINSTEP: prdata = {25'd0, cfg_q.min_step};
			REG_TPS: prdata = {22'd0, cfg_q.tps};
			default: prdata = 32'd0;
		endcase
	end

endmodule

@@ hdl/tlc_digits.sv @@
// ----------------------------------------------------------------------------
// tlc_digits
// Splits a 7-bit count into tens and ones and encodes both digits.
// ----------------------------------------------------------------------------
module tlc_digits import tlc_pkg::*; (
	input  logic [6:0] count,
	output logic [7:0] seg_tens,
	output logic [7:0] seg_ones
);

	logic [14:0] prod;
	logic [3:0] tens;
	logic [6:0] tens_x10;
	logic [6:0] rem;

	// count * 205 / 2048 == count / 10 for every 7-bit value
	assign prod = {8'd0, count} * 15'd205;
	assign tens = prod[14:11];
	assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
	assign rem = count - tens_x10;

	assign seg_tens = seg_code(tens);
	assign seg_ones = seg_code(rem[3:0]);

endmodule

@@ hdl/tlc_core.sv @@
// ----------------------------------------------------------------------------
// tlc_core
// Controller state and its single-pass update: keys, tick count, second
// handling and lamp refresh.
// ----------------------------------------------------------------------------
module tlc_core import tlc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic tick,
	input  logic [3:0] keys_n,
	input  cfg_t cfg,
	output res_t res
);

	logic run_q, held_q;
	logic [9:0] ms_q;
	logic [6:0] sns_q, swe_q, cns_q, cwe_q;
	logic [5:0] lamp_q;

	logic [3:0] pressed;
	logic [7:0] add_sns, add_swe, add_cns, add_cwe;
	logic add_ok, sub_ok;
	logic [6:0] adj7, yel7;

	logic run_k, held_k;
	logic [6:0] sns_k, swe_k, cns_k, cwe_k;
	logic [9:0] ms_inc, ms_d;
	logic sec;
	logic ns_red_k, ns_red_d;
	logic [6:0] cns_dec, cwe_dec, green, red, red_d;
	logic [6:0] sns_d, swe_d, cns_d, cwe_d;
	logic [5:0] lamp_d;

	assign pressed = ~keys_n;
	assign adj7 = {3'd0, cfg.adjust};
	assign yel7 = {3'd0, cfg.yellow};
	assign add_sns = {1'b0, sns_q} + {1'b0, adj7};
	assign add_swe = {1'b0, swe_q} + {1'b0, adj7};
	assign add_cns = {1'b0, cns_q} + {1'b0, adj7};
	assign add_cwe = {1'b0, cwe_q} + {1'b0, adj7};
	assign add_ok = (add_sns <= COUNT_MAX) && (add_swe <= COUNT_MAX) &&
		(add_cns <= COUNT_MAX) && (add_cwe <= COUNT_MAX);
	assign sub_ok = (sns_q > cfg.min_step) && (swe_q > cfg.min_step);
	assign ms_inc = ms_q + 10'd1;

	always_comb begin
		run_k = run_q;
		held_k = held_q;
		sns_k = sns_q;
		swe_k = swe_q;
		cns_k = cns_q;
		cwe_k = cwe_q;
		if (!held_q && pressed != 4'd0) begin
			held_k = 1'b1;
			if (pressed[KEY_RUN]) begin
				run_k = 1'b1;
			end else if (pressed[KEY_HALT]) begin
				run_k = 1'b0;
			end else if (pressed[KEY_ADD]) begin
				if (add_ok) begin
					sns_k = add_sns[6:0];
					swe_k = add_swe[6:0];
					cns_k = add_cns[6:0];
					cwe_k = add_cwe[6:0];
				end
			end else if (sub_ok) begin
				sns_k = (sns_q > adj7) ? sns_q - adj7 : 7'd0;
				swe_k = (swe_q > adj7) ? swe_q - adj7 : 7'd0;
			end
		end else if (pressed == 4'd0) begin
			held_k = 1'b0;
		end

		sec = 1'b0;
		ms_d = ms_q;
		if (run_k && tick) begin
			if (ms_inc >= cfg.tps) begin
				ms_d = 10'd0;
				sec = 1'b1;
			end else begin
				ms_d = ms_inc;
			end
		end

		ns_red_k = sns_k > swe_k;
		cns_dec = (cns_k != 7'd0) ? cns_k - 7'd1 : 7'd0;
		cwe_dec = (cwe_k != 7'd0) ? cwe_k - 7'd1 : 7'd0;
		green = ns_red_k ? cwe_dec : cns_dec;
		red = ns_red_k ? cns_dec : cwe_dec;

		sns_d = sns_k;
		swe_d = swe_k;
		cns_d = cns_k;
		cwe_d = cwe_k;
		lamp_d = lamp_q;
		if (sec) begin
			cns_d = cns_dec;
			cwe_d = cwe_dec;
			if (green == 7'd0) begin
				if (red == yel7) begin
					if (ns_red_k) begin
						cwe_d = yel7;
					end else begin
						cns_d = yel7;
					end
				end else begin
					sns_d = swe_k;
					swe_d = sns_k;
					cns_d = swe_k;
					cwe_d = sns_k;
				end
			end
			ns_red_d = sns_d > swe_d;
			red_d = ns_red_d ? cns_d : cwe_d;
			if (red_d > yel7) begin
				lamp_d = ns_red_d ? {LAMP_GREEN, LAMP_RED} : {LAMP_RED, LAMP_GREEN};
			end else begin
				lamp_d = ns_red_d ? {LAMP_YELLOW, LAMP_RED} : {LAMP_RED, LAMP_YELLOW};
			end
		end else begin
			ns_red_d = ns_red_k;
			red_d = red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			held_q <= 1'b0;
			ms_q <= 10'd0;
			sns_q <= STEP_NS_RST;
			swe_q <= STEP_WE_RST;
			cns_q <= STEP_NS_RST;
			cwe_q <= STEP_WE_RST;
			lamp_q <= {LAMP_ALL, LAMP_ALL};
		end else if (en) begin
			run_q <= run_k;
			held_q <= held_k;
			ms_q <= ms_d;
			sns_q <= sns_d;
			swe_q <= swe_d;
			cns_q <= cns_d;
			cwe_q <= cwe_d;
			lamp_q <= lamp_d;
		end
	end

	assign res.lamps_ns = lamp_d[2:0];
	assign res.lamps_we = lamp_d[5:3];
	assign res.count_ns = cns_d;
	assign res.count_we = cwe_d;
	assign res.running = run_k;

endmodule

@@ hdl/traffic_light_controller_unit.sv @@
// ----------------------------------------------------------------------------
// traffic_light_controller_unit
// Two-way traffic light controller: keys, millisecond ticks, lamps and
// seven-segment count digits over a stream interface, APB configuration.
// ----------------------------------------------------------------------------
// Pipeline: an accepted sample is held in the input register, then the state
// update is written into the result register.
// Throughput: one sample per cycle; the input register keeps accepting while
// a result waits, stalling only when both stages are full.
// Reset: arst_n clears stages, controller state and registers to defaults.
module traffic_light_controller_unit import tlc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,    // [0] tick, [4:1] keys_n, [7:5] zero
	output logic m_tvalid,
	input  logic m_tready,
	output logic [55:0] m_tdata,   // [2:0] lamps_ns, [5:3] lamps_we, [12:6] count_ns_out,
	                               // [19:13] count_we_out, [27:20] seg_we_tens,
	                               // [35:28] seg_we_ones, [43:36] seg_ns_tens,
	                               // [51:44] seg_ns_ones, [52] running, [55:53] zero
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg;
	res_t res;
	logic v_s1, v_s2, adv;
	logic tick_s1;
	logic [3:0] keys_s1;
	logic [7:0] we_tens, we_ones, ns_tens, ns_ones;
	logic [55:0] data_s2;

	assign pready = 1'b1;

	tlc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	assign adv = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1 <= s_tdata[0];
			keys_s1 <= s_tdata[4:1];
		end
	end

	tlc_core u_core (
		.clk(clk), .arst_n(arst_n), .en(adv), .tick(tick_s1), .keys_n(keys_s1),
		.cfg(cfg), .res(res)
	);

	tlc_digits u_dig_we (.count(res.count_we), .seg_tens(we_tens), .seg_ones(we_ones));
	tlc_digits u_dig_ns (.count(res.count_ns), .seg_tens(ns_tens), .seg_ones(ns_ones));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || m_tready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {3'd0, res.running, ns_ones, ns_tens, we_ones, we_tens,
				res.count_we, res.count_ns, res.lamps_we, res.lamps_ns};
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata = data_s2;

	a_counts_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[12:6] <= 7'd99) && (m_tdata[19:13] <= 7'd99))
		else $error("count out of range");

	a_one_red: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != LAMP_ALL) |-> (m_tdata[2] != m_tdata[5]))
		else $error("red lamp not exclusive");

	a_lamp_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tdata[2:0]) || (m_tdata[2:0] == LAMP_ALL))
		else $error("bad lamp pattern");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1)
		else $error("input stage item lost");

endmodule

@@ tb/tlc_display_checker.sv @@
// ----------------------------------------------------------------------------
// tlc_display_checker
// Watches the sample, display and register channels of the traffic light
// controller, predicts every display transaction from its own copy of the
// controller state and compares each one field by field.
// ----------------------------------------------------------------------------
module tlc_display_checker import tlc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [7:0] s_tdata,    // [0] tick, [4:1] keys_n, [7:5] zero
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [55:0] m_tdata,   // [2:0] lamps_ns, [5:3] lamps_we, [12:6] count_ns_out,
	                               // [19:13] count_we_out, [27:20] seg_we_tens,
	                               // [35:28] seg_we_ones, [43:36] seg_ns_tens,
	                               // [51:44] seg_ns_ones, [52] running, [55:53] zero
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int mismatches,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] lamps_ns;
		logic [2:0] lamps_we;
		logic [6:0] count_ns;
		logic [6:0] count_we;
		logic [7:0] seg_we_tens;
		logic [7:0] seg_we_ones;
		logic [7:0] seg_ns_tens;
		logic [7:0] seg_ns_ones;
		logic running;
	} display_t;

	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};
	localparam int COUNT_LIMIT = 99;

	cfg_t cfg;
	logic run_flag;
	logic key_held;
	logic [9:0] ms_count;
	logic [6:0] step_ns, step_we, count_ns, count_we;
	logic [2:0] lamp_ns, lamp_we;
	display_t expected_frames [$];

	initial mismatches = 0;
	initial outstanding = 0;

	function automatic void restore_defaults();
		cfg.yellow = YELLOW_RST;
		cfg.adjust = ADJUST_RST;
		cfg.min_step = MINSTEP_RST;
		cfg.tps = TPS_RST;
		run_flag = 1'b0;
		key_held = 1'b0;
		ms_count = '0;
		step_ns = STEP_NS_RST;
		step_we = STEP_WE_RST;
		count_ns = STEP_NS_RST;
		count_we = STEP_WE_RST;
		lamp_ns = LAMP_ALL;
		lamp_we = LAMP_ALL;
	endfunction

	function automatic logic [7:0] digit_code(input int digit);
		if (digit > 9) begin
			return SEG_BLANK;
		end
		return ~DIGIT_SEGS[digit];
	endfunction

	function automatic void apply_keys(input logic [3:0] keys_n);
		logic [3:0] pressed;
		logic [6:0] adj;
		pressed = ~keys_n;
		adj = {3'd0, cfg.adjust};
		if (!key_held && pressed != 4'd0) begin
			key_held = 1'b1;
			if (pressed[KEY_RUN]) begin
				run_flag = 1'b1;
			end else if (pressed[KEY_HALT]) begin
				run_flag = 1'b0;
			end else if (pressed[KEY_ADD]) begin
				if (int'(step_ns) + int'(adj) <= COUNT_LIMIT &&
				    int'(step_we) + int'(adj) <= COUNT_LIMIT &&
				    int'(count_ns) + int'(adj) <= COUNT_LIMIT &&
				    int'(count_we) + int'(adj) <= COUNT_LIMIT) begin
					step_ns = step_ns + adj;
					step_we = step_we + adj;
					count_ns = count_ns + adj;
					count_we = count_we + adj;
				end
			end else begin
				if (step_ns > cfg.min_step && step_we > cfg.min_step) begin
					step_ns = (step_ns > adj) ? step_ns - adj : 7'd0;
					step_we = (step_we > adj) ? step_we - adj : 7'd0;
				end
			end
		end else if (pressed == 4'd0) begin
			key_held = 1'b0;
		end
	endfunction

	function automatic void elapse_second();
		logic ns_red;
		logic [6:0] green, red, swap, yel;
		yel = {3'd0, cfg.yellow};
		ns_red = step_ns > step_we;
		if (count_ns != 0) count_ns = count_ns - 7'd1;
		if (count_we != 0) count_we = count_we - 7'd1;
		green = ns_red ? count_we : count_ns;
		red = ns_red ? count_ns : count_we;
		if (green == 0) begin
			if (red == yel) begin
				if (ns_red) count_we = yel;
				else count_ns = yel;
			end else begin
				swap = step_ns;
				step_ns = step_we;
				step_we = swap;
				count_ns = step_ns;
				count_we = step_we;
			end
		end
		// lamps follow the phase as it stands after the swap
		ns_red = step_ns > step_we;
		red = ns_red ? count_ns : count_we;
		if (red > yel) begin
			lamp_ns = ns_red ? LAMP_RED : LAMP_GREEN;
			lamp_we = ns_red ? LAMP_GREEN : LAMP_RED;
		end else begin
			lamp_ns = ns_red ? LAMP_RED : LAMP_YELLOW;
			lamp_we = ns_red ? LAMP_YELLOW : LAMP_RED;
		end
	endfunction

	function automatic display_t next_display(input logic tick, input logic [3:0] keys_n);
		display_t d;
		apply_keys(keys_n);
		if (run_flag && tick) begin
			ms_count = ms_count + 10'd1;
			if (ms_count >= cfg.tps) begin
				ms_count = '0;
				elapse_second();
			end
		end
		d.lamps_ns = lamp_ns;
		d.lamps_we = lamp_we;
		d.count_ns = count_ns;
		d.count_we = count_we;
		d.seg_we_tens = digit_code(int'(count_we) / 10);
		d.seg_we_ones = digit_code(int'(count_we) % 10);
		d.seg_ns_tens = digit_code(int'(count_ns) / 10);
		d.seg_ns_ones = digit_code(int'(count_ns) % 10);
		d.running = run_flag;
		return d;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		display_t want;
		if (!arst_n) begin
			restore_defaults();
			expected_frames.delete();
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_YELLOW: cfg.yellow = pwdata[3:0];
					REG_ADJUST: cfg.adjust = pwdata[3:0];
					REG_MINSTEP: cfg.min_step = pwdata[6:0];
					REG_TPS: cfg.tps = pwdata[9:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_frames.size() == 0) begin
					$error("display transaction with nothing pending");
					mismatches++;
				end else begin
					want = expected_frames.pop_front();
					check_field("lamps_ns", want.lamps_ns, m_tdata[2:0]);
					check_field("lamps_we", want.lamps_we, m_tdata[5:3]);
					check_field("count_ns_out", want.count_ns, m_tdata[12:6]);
					check_field("count_we_out", want.count_we, m_tdata[19:13]);
					check_field("seg_we_tens", want.seg_we_tens, m_tdata[27:20]);
					check_field("seg_we_ones", want.seg_we_ones, m_tdata[35:28]);
					check_field("seg_ns_tens", want.seg_ns_tens, m_tdata[43:36]);
					check_field("seg_ns_ones", want.seg_ns_ones, m_tdata[51:44]);
					check_field("running", want.running, m_tdata[52]);
				end
			end
			if (s_tvalid && s_tready) begin
				expected_frames.push_back(next_display(s_tdata[0], s_tdata[4:1]));
			end
			outstanding = expected_frames.size();
		end
	end

endmodule

@@ tb/traffic_light_controller_unit_test.sv @@
// ----------------------------------------------------------------------------
// traffic_light_controller_unit_test
// Drives key and tick samples through the traffic light controller under
// several register settings, with random gaps and back-pressure; the checker
// beside the block predicts and compares every display transaction.
// ----------------------------------------------------------------------------
module traffic_light_controller_unit_test import tlc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_SUB = 3;
	localparam logic [3:0] KEYS_IDLE = 4'hf;
	localparam logic [3:0] KEYS_ALL = 4'h0;

	typedef struct {
		int yellow;
		int adjust;
		int min_step;
		int tps;
		int items;
	} phase_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [55:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic steady;
	int check_errors;
	int pending;

	traffic_light_controller_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tlc_display_checker u_display_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(check_errors), .outstanding(pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 15);
	end

	function automatic logic [3:0] press(input int key);
		return ~(4'b0001 << key);
	endfunction

	task automatic send_reading(input logic tick, input logic [3:0] keys_n);
		if (!steady) begin
			while ($urandom_range(0, 99) < 15) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, keys_n, tick};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every pending display transaction
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// leaves psel high so that writes can follow back to back
	task automatic write_reg(input logic [1:0] idx, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic load_settings(input phase_t p);
		write_reg(REG_YELLOW, p.yellow);
		write_reg(REG_ADJUST, p.adjust);
		write_reg(REG_MINSTEP, p.min_step);
		write_reg(REG_TPS, p.tps);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_random();
		int r;
		logic [3:0] keys_n;
		r = $urandom_range(0, 99);
		if (r < 65) keys_n = KEYS_IDLE;
		else if (r < 75) keys_n = press(KEY_RUN);
		else if (r < 78) keys_n = press(KEY_HALT);
		else if (r < 87) keys_n = press(KEY_ADD);
		else if (r < 95) keys_n = press(KEY_SUB);
		else keys_n = 4'($urandom_range(0, 15));
		send_reading($urandom_range(0, 99) < 70, keys_n);
	endtask

	initial begin
		phase_t plan [6];
		phase_t fast;
		plan[0] = '{15, 1, 99, 1, 250};
		plan[1] = '{1, 15, 0, 2, 250};
		plan[2] = '{3, 5, 15, 3, 250};
		plan[3] = '{8, 7, 50, 1023, 150};
		plan[4] = '{2, 4, 30, 5, 300};
		plan[5] = '{0, 0, 0, 0, 300};
		fast = '{1, 15, 0, 0, 0};

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ticks while stopped, each key, held keys, priorities
		send_reading(1'b0, KEYS_IDLE);
		send_reading(1'b1, KEYS_IDLE);
		send_reading(1'b0, press(KEY_RUN));
		send_reading(1'b1, press(KEY_RUN));
		send_reading(1'b1, KEYS_ALL);
		send_reading(1'b1, KEYS_IDLE);
		send_reading(1'b1, press(KEY_ADD));
		send_reading(1'b0, KEYS_IDLE);
		send_reading(1'b0, press(KEY_SUB));
		send_reading(1'b0, KEYS_IDLE);
		send_reading(1'b0, press(KEY_RUN) & press(KEY_HALT));
		send_reading(1'b1, KEYS_IDLE);
		send_reading(1'b1, press(KEY_HALT));
		send_reading(1'b1, KEYS_IDLE);
		send_reading(1'b0, press(KEY_ADD) & press(KEY_SUB));
		send_reading(1'b0, KEYS_IDLE);
		drain();

		// zero tick count: a second on every running tick; repeated add, then sub presses
		load_settings(fast);
		send_reading(1'b1, press(KEY_RUN));
		for (int i = 0; i < 4; i++) begin
			send_reading(1'b1, press(KEY_ADD));
			send_reading(1'b1, KEYS_IDLE);
		end
		for (int i = 0; i < 3; i++) begin
			send_reading(1'b0, press(KEY_SUB));
			send_reading(1'b1, KEYS_IDLE);
		end
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				plan[5].yellow = $urandom_range(1, 15);
				plan[5].adjust = $urandom_range(1, 15);
				plan[5].min_step = $urandom_range(0, 99);
				plan[5].tps = $urandom_range(1, 8);
			end
			steady = (ph == 0);
			load_settings(plan[ph]);
			send_reading(1'b0, press(KEY_RUN));
			for (int n = 0; n < plan[ph].items; n++) begin
				if (ph == 2 && n == 120) drain();
				send_random();
			end
			drain();
		end

		steady = 1'b0;
		repeat (20) @(posedge clk);
		if (check_errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
